[hw/rtl/prue_pkg.sv]
// Package for the particle ring update engine.
// Holds the controller state type, the stored record types and fixed codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prue_pkg;

    // Input command codes
    localparam logic [1:0] CMD_EMIT   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_KILL   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_LIFE  = 2'd0;
    localparam logic [1:0] CFG_LIFE_DEC    = 2'd1;
    localparam logic [1:0] CFG_RAD_GROWTH  = 2'd2;
    localparam logic [1:0] CFG_BRIGHTNESS  = 2'd3;

    // Radius of a new particle, 5.0 in Q16.8
    localparam logic [23:0] EMIT_RADIUS = 24'd1280;
    localparam logic [23:0] RADIUS_MAX  = 24'hFFFFFF;
    localparam logic [16:0] COLOR_ONE   = 17'h10000;
    localparam int unsigned DIV_STEPS   = 16;

    // Controller states
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_BLANK = 11'b000_0000_0010,
        S_RD    = 11'b000_0000_0100,
        S_CALC  = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_CHK   = 11'b000_0010_0000,
        S_DIV   = 11'b000_0100_0000,
        S_STORE = 11'b000_1000_0000,
        S_FIN   = 11'b001_0000_0000,
        S_DRD   = 11'b010_0000_0000,
        S_DLD   = 11'b100_0000_0000
    } t_state;

    // One stored particle
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [15:0] life;
        logic [23:0] rad;
    } t_part;

    // One buffered update result
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [23:0] rad;
        logic [16:0] color;
        logic [15:0] life;
        logic        dead;
    } t_res;

endpackage

`default_nettype wire

[hw/rtl/particle_ring_update_engine.sv]
// Particle ring update engine: ring store of particles with update walk.
// Depends on prue_pkg.
//
// Usage:
//  Input channel (i_s_*): one item per command; tuser carries the command
//  (emit, update tick, kill). Emit and kill give one blank result item.
//  An update tick walks the live particles oldest first, one at a time:
//  memory read, update and write-back, two multiplies, a 16-step
//  restoring divider for the gray level, then the result goes into a
//  result memory. The divider is skipped when the particle is dead or
//  its gray level clamps at full. Once the walk is done the dead count
//  is dropped from the front and the buffered results are sent with the
//  final live count, each read from the buffer before it is loaded.
//  Emit, kill and an empty tick load the output register from a blank
//  state once it is free; then the next item can be taken.
//  Output channel (o_m_*): a single output register; a stalled receiver
//  holds the walk's drain, and a new command is accepted while the last
//  result still waits in that register.
//  Config channel: always ready, write only while the block is idle.
//  Reset clears the live count and oldest index; particle memory is not
//  cleared since only live slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module particle_ring_update_engine #(
    parameter int RING_DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Config write channel
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [15:0]  i_cfg_data,
    // Input item channel
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // tdata: pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96],
    //        kill_count[134:128], zero pad [135]
    input  wire  [135:0] i_s_tdata,
    // tuser: cmd[1:0]
    input  wire  [1:0]   i_s_tuser,
    // Result item channel
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // tdata: out_pos_x[31:0], out_pos_y[63:32], out_radius[87:64],
    //        out_color[104:88], out_life[120:105], is_dead[121],
    //        live_total[128:122], zero pad [135:129]
    output logic [135:0] o_m_tdata,
    // tuser: particle_valid[0]
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(RING_DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(RING_DEPTH);

    // Memories
    prue_pkg::t_part st_mem [RING_DEPTH];
    prue_pkg::t_res  res_mem[RING_DEPTH];
    prue_pkg::t_part r_rd;
    prue_pkg::t_res  r_res_rd;

    // Config registers
    logic [14:0] r_start_life, r_life_dec;
    logic [15:0] r_rad_growth, r_brightness;

    // Control
    prue_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_live, n_live;
    logic [IW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_dead, n_dead;
    logic [3:0]    r_cnt, n_cnt;

    // Datapath
    logic [31:0] r_px, n_px, r_py, n_py;
    logic [15:0] r_life, n_life;
    logic [23:0] r_rad, n_rad;
    logic [30:0] r_num, n_num;
    logic [47:0] r_den, n_den;
    logic [47:0] r_rem, n_rem;
    logic [15:0] r_q, n_q;
    logic [16:0] r_color, n_color;

    // Output register
    logic         r_ovalid;
    logic [135:0] r_odata, n_odata;
    logic         r_ouser, n_ouser;
    logic         r_olast, n_olast;
    logic         out_load;

    // Memory write ports
    logic            st_we;
    logic [IW-1:0]   st_waddr;
    prue_pkg::t_part st_wdata;
    logic            res_we;

    // Combinational helpers
    logic            accept, out_free;
    logic [1:0]      in_cmd;
    logic [6:0]      drop_n;
    logic [SW-1:0]   sum_ring;
    logic [IW-1:0]   sum_wrap;
    logic signed [16:0] life_sub;
    logic [24:0]     rad_sum;
    logic [48:0]     div_t;
    logic [IW-1:0]   slot_inc;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == prue_pkg::S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_ovalid || i_m_tready;
    assign in_cmd      = i_s_tuser;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;
    assign o_m_tlast   = r_olast;

    assign slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_life <= 15'd128;
            r_life_dec   <= 15'd13;
            r_rad_growth <= 16'd256;
            r_brightness <= 16'd2048;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                prue_pkg::CFG_START_LIFE: r_start_life <= i_cfg_data[14:0];
                prue_pkg::CFG_LIFE_DEC:   r_life_dec   <= i_cfg_data[14:0];
                prue_pkg::CFG_RAD_GROWTH: r_rad_growth <= i_cfg_data;
                prue_pkg::CFG_BRIGHTNESS: r_brightness <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Particle store: one write port, registered read at the walk slot
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        r_rd <= st_mem[r_slot];
    end

    // Result buffer: written per particle, read back in order when draining
    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[r_idx[IW-1:0]] <= '{px: r_px, py: r_py, rad: r_rad,
                                        color: r_color, life: r_life,
                                        dead: r_life[15] || (r_life == '0)};
        end
        r_res_rd <= res_mem[r_idx[IW-1:0]];
    end

    // Ring index arithmetic: front drop amount and wrapped slot sum
    always_comb begin
        drop_n = (r_state == prue_pkg::S_FIN) ? 7'(r_dead) : i_s_tdata[134:128];
        if ((r_state == prue_pkg::S_IDLE) && (in_cmd == prue_pkg::CMD_EMIT)) begin
            sum_ring = SW'(r_oldest) + SW'(r_live);
        end else begin
            sum_ring = SW'(r_oldest) + SW'(drop_n[CW-1:0]);
        end
        sum_wrap = (sum_ring >= DEPTH_S) ? IW'(sum_ring - DEPTH_S) : IW'(sum_ring);
    end

    // Per-particle update terms
    always_comb begin
        life_sub = $signed({r_rd.life[15], r_rd.life}) - $signed({2'b00, r_life_dec});
        rad_sum  = {1'b0, r_rd.rad} + {9'b0, r_rad_growth};
        div_t    = {r_rem, 1'b0};
    end

    // Main sequencer
    always_comb begin
        n_state  = r_state;
        n_oldest = r_oldest;
        n_live   = r_live;
        n_slot   = r_slot;
        n_idx    = r_idx;
        n_n      = r_n;
        n_dead   = r_dead;
        n_cnt    = r_cnt;
        n_px     = r_px;
        n_py     = r_py;
        n_life   = r_life;
        n_rad    = r_rad;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_q      = r_q;
        n_color  = r_color;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        out_load = 1'b0;
        st_we    = 1'b0;
        st_waddr = r_slot;
        st_wdata = r_rd;
        res_we   = 1'b0;

        case (r_state)
            prue_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = prue_pkg::S_BLANK;
                    case (in_cmd)
                        prue_pkg::CMD_EMIT: begin
                            st_we    = 1'b1;
                            st_wdata = '{px: i_s_tdata[31:0], py: i_s_tdata[63:32],
                                         vx: i_s_tdata[95:64], vy: i_s_tdata[127:96],
                                         life: {1'b0, r_start_life},
                                         rad: prue_pkg::EMIT_RADIUS};
                            if (r_live < DEPTH_C) begin
                                st_waddr = sum_wrap;
                                n_live   = r_live + 1'b1;
                            end else begin
                                st_waddr = r_oldest;
                                n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
                            end
                        end
                        prue_pkg::CMD_UPDATE: begin
                            if (r_live != '0) begin
                                n_state = prue_pkg::S_RD;
                                n_n     = r_live;
                                n_idx   = '0;
                                n_dead  = '0;
                                n_slot  = r_oldest;
                            end
                        end
                        prue_pkg::CMD_KILL: begin
                            if (7'(r_live) >= drop_n) begin
                                n_live   = r_live - drop_n[CW-1:0];
                                n_oldest = sum_wrap;
                            end else begin
                                n_live   = '0;
                                n_oldest = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Blank result carrying the live count
            prue_pkg::S_BLANK: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_odata  = '0;
                    n_odata[128:122] = 7'(r_live);
                    n_ouser  = 1'b0;
                    n_olast  = 1'b1;
                    n_state  = prue_pkg::S_IDLE;
                end
            end

            // Read of r_slot is in flight
            prue_pkg::S_RD: begin
                n_state = prue_pkg::S_CALC;
            end

            // Update the particle and write it back
            prue_pkg::S_CALC: begin
                n_life = (life_sub < -17'sd32768) ? 16'h8000 : life_sub[15:0];
                n_rad  = rad_sum[24] ? prue_pkg::RADIUS_MAX : rad_sum[23:0];
                n_px   = r_rd.px + r_rd.vx;
                n_py   = r_rd.py + r_rd.vy;
                st_we    = 1'b1;
                st_waddr = r_slot;
                st_wdata = '{px: n_px, py: n_py, vx: r_rd.vx, vy: r_rd.vy,
                             life: n_life, rad: n_rad};
                if (n_life[15] || (n_life == '0)) begin
                    n_dead = r_dead + 1'b1;
                end
                n_state = prue_pkg::S_MUL;
            end

            // Numerator and denominator of the gray level
            prue_pkg::S_MUL: begin
                n_num   = 31'(r_brightness * r_life[14:0]);
                n_den   = r_rad * r_rad;
                n_state = prue_pkg::S_CHK;
            end

            prue_pkg::S_CHK: begin
                if (r_life[15] || (r_life == '0)) begin
                    n_color = '0;
                    n_state = prue_pkg::S_STORE;
                end else if (48'(r_num) >= r_den) begin
                    n_color = prue_pkg::COLOR_ONE;
                    n_state = prue_pkg::S_STORE;
                end else begin
                    n_rem   = 48'(r_num);
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = prue_pkg::S_DIV;
                end
            end

            // Restoring division, one quotient bit a cycle
            prue_pkg::S_DIV: begin
                if (div_t >= {1'b0, r_den}) begin
                    n_rem = 48'(div_t - {1'b0, r_den});
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = div_t[47:0];
                    n_q   = {r_q[14:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'(prue_pkg::DIV_STEPS - 1)) begin
                    n_color = {1'b0, n_q};
                    n_state = prue_pkg::S_STORE;
                end
            end

            prue_pkg::S_STORE: begin
                res_we = 1'b1;
                if (r_idx == r_n - 1'b1) begin
                    n_state = prue_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_slot  = slot_inc;
                    n_state = prue_pkg::S_RD;
                end
            end

            // Drop the dead count from the front
            prue_pkg::S_FIN: begin
                n_live   = r_live - r_dead;
                n_oldest = sum_wrap;
                n_idx    = '0;
                n_state  = prue_pkg::S_DRD;
            end

            prue_pkg::S_DRD: begin
                n_state = prue_pkg::S_DLD;
            end

            prue_pkg::S_DLD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_odata  = {7'b0, 7'(r_live), r_res_rd.dead, r_res_rd.life,
                                r_res_rd.color, r_res_rd.rad, r_res_rd.py, r_res_rd.px};
                    n_ouser  = 1'b1;
                    n_olast  = (r_idx == r_n - 1'b1);
                    if (n_olast) begin
                        n_state = prue_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = prue_pkg::S_DRD;
                    end
                end
            end

            default: n_state = prue_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= prue_pkg::S_IDLE;
            r_oldest <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_live   <= n_live;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_dead  <= n_dead;
        r_cnt   <= n_cnt;
        r_px    <= n_px;
        r_py    <= n_py;
        r_life  <= n_life;
        r_rad   <= n_rad;
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_color <= n_color;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    // Checks
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= DEPTH_C)
        else $error("live count above ring depth");

    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest <= LAST_SLOT)
        else $error("oldest index outside ring");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != prue_pkg::S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prue_pkg::S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_dead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prue_pkg::S_FIN) |-> (r_dead <= r_live))
        else $error("dead count exceeds live count");

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for the particle ring update engine.
// Drives commands and register writes, predicts every result item and checks them in order.
// Depends on prue_pkg and particle_ring_update_engine.
`timescale 1ns / 1ps

module tb;

    localparam int          DEPTH      = 64;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          STALL_MAX  = 20000;
    // a full tick walk finishes every particle before the first result
    localparam int          SETTLE     = 100;

    typedef struct {
        bit        pvalid;
        bit [31:0] px;
        bit [31:0] py;
        bit [23:0] rad;
        bit [16:0] color;
        bit [15:0] life;
        bit        dead;
        bit [6:0]  live;
        bit        last;
    } part_res_t;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [15:0]    i_cfg_data;
    logic           i_s_tvalid;
    logic           o_s_tready;
    logic [135:0]   i_s_tdata;
    logic [1:0]     i_s_tuser;
    logic           o_m_tvalid;
    logic           i_m_tready;
    logic [135:0]   o_m_tdata;
    logic [0:0]     o_m_tuser;
    logic           o_m_tlast;

    particle_ring_update_engine #(.RING_DEPTH(DEPTH)) dut (.*);

    // Shadow copy of the particle store and registers
    bit [31:0]        sh_px [DEPTH];
    bit [31:0]        sh_py [DEPTH];
    bit [31:0]        sh_vx [DEPTH];
    bit [31:0]        sh_vy [DEPTH];
    int               sh_life [DEPTH];
    bit [23:0]        sh_rad [DEPTH];
    int               sh_head;
    int               sh_count;
    bit [14:0]        reg_start_life;
    bit [14:0]        reg_life_dec;
    bit [15:0]        reg_growth;
    bit [15:0]        reg_bright;

    part_res_t        pending_particles[$];
    int               mismatches;
    int               burst_left;
    int               rx_hold_req;
    int               idle_cycles;

    // Clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    task automatic report(input string what, input bit [31:0] got, input bit [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic bit [16:0] gray_of(input int life, input bit [23:0] rad);
        bit [63:0] num;
        bit [63:0] den;
        if (life <= 0) return 17'd0;
        num = 64'(reg_bright) * 64'(life);
        den = 64'(rad) * 64'(rad);
        if (num >= den) return prue_pkg::COLOR_ONE;
        return 17'((num << 16) / den);
    endfunction

    function automatic void drop_oldest(input int n);
        if (sh_count >= n) begin
            sh_count -= n;
            sh_head = (sh_head + n) % DEPTH;
        end else begin
            sh_count = 0;
            sh_head  = 0;
        end
    endfunction

    function automatic void push_blank();
        part_res_t r;
        r = '{default: 0};
        r.live = 7'(sh_count);
        r.last = 1'b1;
        pending_particles.push_back(r);
    endfunction

    // Works out the result items of one accepted command
    function automatic void compute_particle_results(input logic [1:0] cmd,
            input logic [135:0] d);
        part_res_t walk[$];
        part_res_t r;
        int slot, n, dead, lf, i;
        bit [24:0] rd;
        case (cmd)
            prue_pkg::CMD_EMIT: begin
                if (sh_count < DEPTH) begin
                    slot = (sh_head + sh_count) % DEPTH;
                    sh_count++;
                end else begin
                    slot = sh_head;
                    sh_head = (sh_head + 1) % DEPTH;
                end
                sh_px[slot]   = d[31:0];
                sh_py[slot]   = d[63:32];
                sh_vx[slot]   = d[95:64];
                sh_vy[slot]   = d[127:96];
                sh_life[slot] = int'(reg_start_life);
                sh_rad[slot]  = prue_pkg::EMIT_RADIUS;
                push_blank();
            end
            prue_pkg::CMD_UPDATE: begin
                n = sh_count;
                dead = 0;
                if (n == 0) begin
                    push_blank();
                end else begin
                    for (i = 0; i < n; i++) begin
                        slot = (sh_head + i) % DEPTH;
                        lf = sh_life[slot] - int'(reg_life_dec);
                        if (lf < -32768) lf = -32768;
                        rd = 25'(sh_rad[slot]) + 25'(reg_growth);
                        if (rd > 25'(prue_pkg::RADIUS_MAX)) rd = 25'(prue_pkg::RADIUS_MAX);
                        sh_life[slot] = lf;
                        sh_rad[slot]  = rd[23:0];
                        sh_px[slot]   = sh_px[slot] + sh_vx[slot];
                        sh_py[slot]   = sh_py[slot] + sh_vy[slot];
                        if (lf <= 0) dead++;
                        r.pvalid = 1'b1;
                        r.px     = sh_px[slot];
                        r.py     = sh_py[slot];
                        r.rad    = rd[23:0];
                        r.color  = gray_of(lf, rd[23:0]);
                        r.life   = lf[15:0];
                        r.dead   = (lf <= 0);
                        r.last   = (i + 1 == n);
                        r.live   = '0;
                        walk.push_back(r);
                    end
                    // dead ones leave from the front, wherever they sat
                    drop_oldest(dead);
                    foreach (walk[k]) begin
                        walk[k].live = 7'(sh_count);
                        pending_particles.push_back(walk[k]);
                    end
                end
            end
            prue_pkg::CMD_KILL: begin
                drop_oldest(int'(d[134:128]));
                push_blank();
            end
            default: push_blank();
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        part_res_t w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_particles.size() == 0) begin
                report("unexpected item", o_m_tdata[31:0], 32'd0);
            end else begin
                w = pending_particles.pop_front();
                if (o_m_tuser[0] !== w.pvalid)
                    report("particle_valid", 32'(o_m_tuser[0]), 32'(w.pvalid));
                if (o_m_tdata[31:0] !== w.px) report("pos_x", o_m_tdata[31:0], w.px);
                if (o_m_tdata[63:32] !== w.py) report("pos_y", o_m_tdata[63:32], w.py);
                if (o_m_tdata[87:64] !== w.rad)
                    report("radius", 32'(o_m_tdata[87:64]), 32'(w.rad));
                if (o_m_tdata[104:88] !== w.color)
                    report("color", 32'(o_m_tdata[104:88]), 32'(w.color));
                if (o_m_tdata[120:105] !== w.life)
                    report("life", 32'(o_m_tdata[120:105]), 32'(w.life));
                if (o_m_tdata[121] !== w.dead)
                    report("is_dead", 32'(o_m_tdata[121]), 32'(w.dead));
                if (o_m_tdata[128:122] !== w.live)
                    report("live_total", 32'(o_m_tdata[128:122]), 32'(w.live));
                if (o_m_tlast !== w.last) report("last", 32'(o_m_tlast), 32'(w.last));
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off
    always @(negedge i_clk) begin
        int mode_cnt;
        int mode;
        if (rx_hold_req > 0) begin
            i_m_tready  = 1'b0;
            rx_hold_req = rx_hold_req - 1;
        end else begin
            if (mode_cnt == 0) begin
                mode     = $urandom_range(0, 2);
                mode_cnt = $urandom_range(50, 300);
            end
            mode_cnt--;
            case (mode)
                0: i_m_tready = 1'b1;
                1: i_m_tready = ($urandom_range(0, 3) != 0);
                default: i_m_tready = (mode_cnt % 5 < 2);
            endcase
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sends one item in bursts with random gaps; called and left at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] px,
            input logic [31:0] py, input logic [31:0] vx, input logic [31:0] vy,
            input logic [6:0] kc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = {1'b0, kc, vy, vx, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        compute_particle_results(cmd, i_s_tdata);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [6:0] kc = 7'd0);
        send_item(cmd, $urandom, $urandom, $urandom, $urandom, kc);
    endtask

    // Waits for every expected item, then for the block to settle
    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending_particles.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_s_tvalid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            prue_pkg::CFG_START_LIFE: reg_start_life = val[14:0];
            prue_pkg::CFG_LIFE_DEC:   reg_life_dec   = val[14:0];
            prue_pkg::CFG_RAD_GROWTH: reg_growth     = val;
            default:                  reg_bright     = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] sl, input logic [15:0] ld,
            input logic [15:0] rg, input logic [15:0] br);
        drain();
        write_reg(prue_pkg::CFG_START_LIFE, sl);
        write_reg(prue_pkg::CFG_LIFE_DEC, ld);
        write_reg(prue_pkg::CFG_RAD_GROWTH, rg);
        write_reg(prue_pkg::CFG_BRIGHTNESS, br);
    endtask

    // Empty store, unused code and field extremes under reset settings
    task automatic test_directed();
        send_cmd(prue_pkg::CMD_UPDATE);
        send_cmd(CMD_UNUSED, 7'h7F);
        send_cmd(prue_pkg::CMD_KILL, 7'd5);
        send_item(prue_pkg::CMD_EMIT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 7'd0);
        send_item(prue_pkg::CMD_EMIT, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                  32'h00000001, 7'd0);
        send_item(prue_pkg::CMD_EMIT, 32'd0, 32'd0, 32'd0, 32'd0, 7'h7F);
        send_item(prue_pkg::CMD_EMIT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 7'd0);
        send_cmd(prue_pkg::CMD_UPDATE);
        send_cmd(prue_pkg::CMD_UPDATE);
        send_cmd(prue_pkg::CMD_KILL, 7'd0);
        send_cmd(prue_pkg::CMD_KILL, 7'd1);
        send_cmd(prue_pkg::CMD_UPDATE);
        send_cmd(prue_pkg::CMD_KILL, 7'd64);
        send_cmd(prue_pkg::CMD_UPDATE);
    endtask

    // Fill past depth so the oldest is replaced, under a long receiver hold-off
    task automatic test_ring_wrap();
        set_regs(16'd32767, 16'd0, 16'd0, 16'd65535);
        rx_hold_req = 600;
        repeat (70) send_cmd(prue_pkg::CMD_EMIT);
        send_cmd(prue_pkg::CMD_UPDATE);
        send_cmd(prue_pkg::CMD_KILL, 7'd3);
        send_cmd(prue_pkg::CMD_UPDATE);
        send_cmd(prue_pkg::CMD_KILL, 7'd64);
    endtask

    // Radius climbs to its ceiling, life saturates at its floor
    task automatic test_saturation();
        set_regs(16'd0, 16'd0, 16'd65535, 16'd0);
        send_cmd(prue_pkg::CMD_EMIT);
        send_cmd(prue_pkg::CMD_EMIT);
        repeat (12) send_cmd(prue_pkg::CMD_UPDATE);
        set_regs(16'd300, 16'd0, 16'd65535, 16'd65535);
        send_cmd(prue_pkg::CMD_KILL, 7'd64);
        send_cmd(prue_pkg::CMD_EMIT);
        repeat (5) send_cmd(prue_pkg::CMD_UPDATE);
        drain();
        rx_hold_req = 0;
        // walk past the ceiling on one particle
        repeat (255) send_cmd(prue_pkg::CMD_UPDATE);
        set_regs(16'd20, 16'd32767, 16'd256, 16'd2048);
        send_cmd(prue_pkg::CMD_EMIT);
        repeat (3) send_cmd(prue_pkg::CMD_UPDATE);
    endtask

    // Random traffic, including the unused code, over several register settings
    task automatic test_random_traffic();
        int p, k, sel;
        logic [15:0] sl, ld;
        for (p = 0; p < 4; p++) begin
            sl = 16'($urandom_range(1, 4000));
            ld = 16'($urandom_range(1, 600));
            set_regs(sl, ld, 16'($urandom), 16'($urandom));
            for (k = 0; k < 26; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 55)       send_cmd(prue_pkg::CMD_EMIT);
                else if (sel < 80)  send_cmd(prue_pkg::CMD_UPDATE);
                else if (sel < 93)  send_cmd(prue_pkg::CMD_KILL, 7'($urandom_range(0, 8)));
                else if (sel < 97)  send_cmd(prue_pkg::CMD_KILL, 7'($urandom_range(0, 64)));
                else                send_cmd(CMD_UNUSED, 7'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        rx_hold_req = 0;
        idle_cycles = 0;
        burst_left  = 0;
        mismatches  = 0;
        sh_head     = 0;
        sh_count    = 0;
        reg_start_life = 15'd128;
        reg_life_dec   = 15'd13;
        reg_growth     = 16'd256;
        reg_bright     = 16'd2048;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_ring_wrap();
        test_saturation();
        test_random_traffic();
        drain();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
